// ===== hw/rtl/btmx_pkg.sv =====
// ----------------------------------------------------------------------------
// btmx_pkg: shared types for the maximum-XOR trie unit
// Transaction payload structs and field codes used by the top level.
// ----------------------------------------------------------------------------
package btmx_pkg;

	localparam int VALUE_W = 32;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [VALUE_W-1:0] value;
		logic               last;
	} item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] max_xor;
		logic               none_stored;
		logic               store_full;
	} result_t;

endpackage

// ===== hw/rtl/btmx_ram.sv =====
// ----------------------------------------------------------------------------
// btmx_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module btmx_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/binary_trie_max_xor_unit.sv =====
// Walk: one trie level per cycle after accept, then a final step to write the leaf on an
//   allocating insert or to fold a query into the maximum.
// Flow: item_stall holds off a new item until the previous one is through, with one
//   node-memory read per level; an insert that runs out of nodes ends early, and a
//   last query holds in its final step while the previous result is still stalled.
// Reset: root links null, node count one, maximum and flags zero; node memory is
//   not cleared, every entry is written when it is allocated.
// ----------------------------------------------------------------------------
// binary_trie_max_xor_unit: maximum-XOR pair finder on a binary trie
// Inserts keys into a node memory bit by bit and queries for the largest XOR,
// reporting the running maximum on the last query and clearing the trie.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_unit #(
	parameter int KEY_BITS  = 32,
	parameter int MAX_NODES = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  btmx_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output btmx_pkg::result_t result
);

	localparam int VW = btmx_pkg::VALUE_W;
	localparam int NW = $clog2(MAX_NODES);
	localparam int UW = NW + 1;
	localparam int CW = $clog2(KEY_BITS + 1);
	localparam int LW = 2 * NW;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_WALK   = 2'd1;
	localparam logic [1:0] ST_ALLOC  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	localparam logic [UW-1:0] USED_MAX = UW'(MAX_NODES);
	localparam logic [NW-1:0] NODE_NULL = '0;

	logic [1:0]          state_q;
	logic [CW-1:0]       cnt_q;
	logic                dead_q;
	logic                cur_root_q;
	logic [LW-1:0]       root_q;
	logic [UW-1:0]       used_q;
	logic [KEY_BITS-1:0] best_q;
	logic                empty_q;
	logic                ovf_q;
	logic                result_valid_q;

	logic [KEY_BITS-1:0] key_q;
	logic                mode_q;
	logic                last_q;
	logic [KEY_BITS-1:0] acc_q;
	logic [NW-1:0]       cur_q;
	btmx_pkg::result_t   result_q;

	logic                accept;
	logic                bit_b;
	logic [LW-1:0]       links;
	logic [NW-1:0]       lnk0;
	logic [NW-1:0]       lnk1;
	logic [NW-1:0]       want;
	logic [NW-1:0]       opp;
	logic [NW-1:0]       walk_next;
	logic [LW-1:0]       parent_upd;
	logic [LW-1:0]       alloc_entry;
	logic                full;
	logic [KEY_BITS-1:0] new_best;
	logic                emit_ok;

	logic                mem_we;
	logic [NW-1:0]       mem_waddr;
	logic [LW-1:0]       mem_wdata;
	logic [LW-1:0]       mem_rdata;

	assign accept     = item_valid && (state_q == ST_IDLE);
	assign item_stall = (state_q != ST_IDLE);

	assign bit_b = key_q[KEY_BITS-1];
	assign links = cur_root_q ? root_q : mem_rdata;
	assign lnk0  = links[NW-1:0];
	assign lnk1  = links[LW-1:NW];
	assign want  = bit_b ? lnk1 : lnk0;
	assign opp   = bit_b ? lnk0 : lnk1;
	assign full  = (used_q >= USED_MAX);

	always_comb begin
		walk_next = want;
		if (mode_q == btmx_pkg::MODE_QUERY && opp != NODE_NULL) begin
			walk_next = opp;
		end
	end

	// replace the chosen child with the node about to be allocated
	assign parent_upd  = bit_b ? {used_q[NW-1:0], lnk0} : {lnk1, used_q[NW-1:0]};
	assign alloc_entry = bit_b ? {used_q[NW-1:0], NODE_NULL} : {NODE_NULL, used_q[NW-1:0]};

	assign new_best = (acc_q > best_q) ? acc_q : best_q;
	assign emit_ok  = !result_valid_q || !result_stall;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = '0;
		unique case (state_q) inside
			ST_WALK: begin
				if (mode_q == btmx_pkg::MODE_INSERT && want == NODE_NULL && !full &&
					!cur_root_q) begin
					mem_we    = 1'b1;
					mem_wdata = parent_upd;
				end
			end
			ST_ALLOC: begin
				mem_we = 1'b1;
				if (cnt_q != '0 && !full) begin
					mem_wdata = alloc_entry;
				end
			end
			ST_IDLE, ST_FINISH: begin
				mem_we = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	btmx_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_NODES)
	) u_node_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (walk_next),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			dead_q         <= 1'b0;
			cur_root_q     <= 1'b1;
			root_q         <= '0;
			used_q         <= UW'(1);
			best_q         <= '0;
			empty_q        <= 1'b0;
			ovf_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && last_q && emit_ok) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q    <= ST_WALK;
						cnt_q      <= CW'(KEY_BITS);
						dead_q     <= 1'b0;
						cur_root_q <= 1'b1;
					end
				end
				ST_WALK: begin
					cnt_q <= cnt_q - CW'(1);
					if (mode_q == btmx_pkg::MODE_QUERY) begin
						if (!dead_q && opp == NODE_NULL && want == NODE_NULL) begin
							// dead end; an empty root means nothing is stored
							dead_q <= 1'b1;
							if (cur_root_q) begin
								empty_q <= 1'b1;
							end
						end else if (!dead_q) begin
							cur_root_q <= 1'b0;
						end
						if (cnt_q == CW'(1)) begin
							state_q <= ST_FINISH;
						end
					end else if (want != NODE_NULL) begin
						cur_root_q <= 1'b0;
						if (cnt_q == CW'(1)) begin
							state_q <= ST_IDLE;
						end
					end else if (full) begin
						ovf_q   <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						if (cur_root_q) begin
							root_q <= parent_upd;
						end
						cur_root_q <= 1'b0;
						used_q     <= used_q + UW'(1);
						state_q    <= ST_ALLOC;
					end
				end
				ST_ALLOC: begin
					if (cnt_q == '0) begin
						state_q <= ST_IDLE;
					end else if (full) begin
						ovf_q   <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						used_q <= used_q + UW'(1);
						cnt_q  <= cnt_q - CW'(1);
					end
				end
				ST_FINISH: begin
					if (!last_q) begin
						best_q  <= new_best;
						state_q <= ST_IDLE;
					end else if (emit_ok) begin
						root_q  <= '0;
						used_q  <= UW'(1);
						best_q  <= '0;
						empty_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					key_q  <= KEY_BITS'(item.value);
					mode_q <= item.mode;
					last_q <= item.last;
					acc_q  <= '0;
				end
			end
			ST_WALK: begin
				key_q <= key_q << 1;
				if (mode_q == btmx_pkg::MODE_QUERY) begin
					acc_q <= (acc_q << 1) |
						KEY_BITS'(!dead_q && opp != NODE_NULL);
					if (!dead_q && (opp != NODE_NULL || want != NODE_NULL)) begin
						cur_q <= walk_next;
					end
				end else if (want != NODE_NULL) begin
					cur_q <= want;
				end else begin
					cur_q <= used_q[NW-1:0];
				end
			end
			ST_ALLOC: begin
				key_q <= key_q << 1;
				cur_q <= used_q[NW-1:0];
			end
			ST_FINISH: begin
				if (last_q && emit_ok) begin
					result_q.max_xor     <= VW'(new_best);
					result_q.none_stored <= empty_q;
					result_q.store_full  <= ovf_q;
				end
			end
			default: begin
				key_q <= key_q;
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// node count stays within the memory and never drops below the root
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q >= UW'(1) && used_q <= USED_MAX)
		else $error("node count out of range");

	// a result only appears out of the finish step
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish");

	// node memory is only written by inserts, never at the root slot
	a_write_insert: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (mode_q == btmx_pkg::MODE_INSERT && cur_q != NODE_NULL))
		else $error("bad node memory write");

	// a walk only starts from idle
	a_walk_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && $past(state_q) != ST_WALK) |-> $past(state_q) == ST_IDLE)
		else $error("walk entered from wrong state");

	// a query that moves on leaves the root behind
	a_query_move: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && mode_q == btmx_pkg::MODE_QUERY && !dead_q &&
		opp != NODE_NULL) |=> !cur_root_q)
		else $error("query step did not leave the root");

endmodule
